FILE: src/tptg_pkg.sv
// ----------------------------------------------------------------------------
// Touch pinch/tap tracker package
// Shared types, constants and codes for the gesture tracker.
// ----------------------------------------------------------------------------
package tptg_pkg;

  localparam int MaxTouches = 10;
  localparam int CoordBits  = 16;
  localparam int IdBits     = 16;
  localparam int SpanBits   = CoordBits + 1;
  localparam int CntBits    = $clog2(MaxTouches + 1);
  localparam int IdxBits    = $clog2(MaxTouches);
  localparam int SqBits     = 2 * SpanBits;
  localparam int RootSteps  = SqBits / 2;
  localparam int StepBits   = $clog2(RootSteps + 1);
  localparam logic [15:0] TapTimeReset = 16'd500;

  localparam logic [2:0] OpStart = 3'd0;
  localparam logic [2:0] OpAdd   = 3'd1;
  localparam logic [2:0] OpMove  = 3'd2;
  localparam logic [2:0] OpEnd   = 3'd3;
  localparam logic [2:0] OpCancel = 3'd4;

  localparam logic [2:0] KindPinchStart = 3'd0;
  localparam logic [2:0] KindPinchScale = 3'd1;
  localparam logic [2:0] KindPinchEnd   = 3'd2;
  localparam logic [2:0] KindTapUp      = 3'd3;
  localparam logic [2:0] KindTapOk      = 3'd4;
  localparam logic [2:0] KindForward    = 3'd5;

  typedef struct packed {
    logic [2:0]                  operation;
    logic [31:0]                 event_time;
    logic [IdBits-1:0]           touch_id;
    logic signed [CoordBits-1:0] touch_x;
    logic signed [CoordBits-1:0] touch_y;
    logic                        last_touch_of_event;
  } item_t;

  typedef struct packed {
    logic [2:0]                  result_kind;
    logic [31:0]                 result_time;
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
    logic [SpanBits-1:0]         span_now;
    logic [SpanBits-1:0]         span_before;
    logic                        table_overflow;
    logic                        last_result;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_SCAN, S_SHIFT, S_DECIDE, S_TAP1, S_TAP2,
    S_SQUARE, S_ROOT, S_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture item
    logic first;       // apply first-item actions
    logic scan;        // examine entry at scan index
    logic shift;       // shift one entry down at scan index
    logic table_done;  // finish table update
    logic emit_end_first;
    logic emit_tap_up;
    logic emit_tap_ok;
    logic square;
    logic root_step;
    logic emit_final;
    logic close_event;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic first_end;   // first item must emit pinch end
    logic scan_last;   // scan index at last valid entry (or table empty)
    logic shift_last;
    logic removing;    // scan index holds the entry to remove
    logic is_last;
    logic tap_hit;
    logic pinch;       // touch_count > 1
    logic root_last;
  } status_t;

endpackage

FILE: src/tptg_datapath.sv
// ----------------------------------------------------------------------------
// Touch pinch/tap tracker datapath
// Touch table, gesture state, squared-distance unit and bit-serial root.
// ----------------------------------------------------------------------------
module tptg_datapath import tptg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  item_t         item,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  cmd_t          cmd,
  output status_t       stat,
  output logic          strobe,
  output result_t       result
);

  logic [IdBits-1:0]           tbl_id [MaxTouches];
  logic signed [CoordBits-1:0] tbl_x  [MaxTouches];
  logic signed [CoordBits-1:0] tbl_y  [MaxTouches];

  logic [15:0]           tap_limit;
  logic                  pinch_active;
  logic [CntBits-1:0]    touch_count;
  logic [31:0]           tap_start_time;
  logic [SpanBits-1:0]   previous_span;
  logic signed [CoordBits-1:0] first_x, first_y;
  logic                  mid_event, removed_this_event, overflow_this_event;

  item_t                 cur;
  logic [CntBits-1:0]    idx;
  logic                  found;
  logic [SqBits-1:0]     rem;
  logic [SqBits-1:0]     root;
  logic [SqBits-1:0]     rbit;
  logic [StepBits-1:0]   rstep;
  logic signed [SpanBits-1:0] dx, dy, sumx, sumy;
  logic [SpanBits-1:0]   adx, ady;
  logic [2*CoordBits-1:0] sqx, sqy;
  logic [SpanBits-1:0]   span;

  logic [IdxBits-1:0]    ix, ixn, lastix;
  logic                  hit;
  logic signed [SpanBits-1:0] fx, fy;
  logic [31:0]           elapsed;

  assign ix     = idx[IdxBits-1:0];
  assign ixn    = IdxBits'(idx + 1'b1);
  assign lastix = IdxBits'(touch_count - 1'b1);
  assign hit    = tbl_id[ix] == cur.touch_id;
  assign span   = root[SpanBits-1:0];
  assign elapsed = cur.event_time - tap_start_time;
  // truncate toward zero
  assign fx = (sumx + SpanBits'(sumx[SpanBits-1])) >>> 1;
  assign fy = (sumy + SpanBits'(sumy[SpanBits-1])) >>> 1;

  // magnitudes fit in CoordBits, so each square is a CoordBits x CoordBits product
  assign adx = dx[SpanBits-1] ? SpanBits'(-dx) : dx;
  assign ady = dy[SpanBits-1] ? SpanBits'(-dy) : dy;
  assign sqx = (2*CoordBits)'(adx[CoordBits-1:0]) * (2*CoordBits)'(adx[CoordBits-1:0]);
  assign sqy = (2*CoordBits)'(ady[CoordBits-1:0]) * (2*CoordBits)'(ady[CoordBits-1:0]);

  always_comb begin
    stat.first_end  = (cur.operation == OpStart || cur.operation == OpCancel) &&
                      pinch_active && !mid_event;
    stat.scan_last  = (idx + 1'b1 >= touch_count);
    stat.shift_last = (idx + 2'd2 >= touch_count);
    stat.removing   = (idx < touch_count) && hit && cur.operation == OpEnd &&
                      !removed_this_event;
    stat.is_last    = cur.last_touch_of_event;
    stat.tap_hit    = cur.operation == OpEnd && elapsed <= 32'(tap_limit);
    stat.pinch      = touch_count > CntBits'(1);
    stat.root_last  = rstep == StepBits'(RootSteps - 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
      idx <= '0;
      found <= 1'b0;
    end
    if (cmd.scan) begin
      if (idx < touch_count && hit) begin
        found <= 1'b1;
        if (cur.operation == OpMove) begin
          tbl_x[ix] <= cur.touch_x;
          tbl_y[ix] <= cur.touch_y;
        end
      end
      // hold the index on the entry to remove; the shift starts there
      if (!stat.removing) idx <= idx + 1'b1;
    end
    if (cmd.shift) begin
      if (!stat.scan_last) begin
        tbl_id[ix] <= tbl_id[ixn];
        tbl_x[ix]  <= tbl_x[ixn];
        tbl_y[ix]  <= tbl_y[ixn];
      end
      idx <= idx + 1'b1;
    end
    if (cmd.table_done) begin
      if ((cur.operation == OpStart || cur.operation == OpAdd) && !found) begin
        if (touch_count < CntBits'(MaxTouches)) begin
          tbl_id[touch_count[IdxBits-1:0]] <= cur.touch_id;
          tbl_x[touch_count[IdxBits-1:0]]  <= cur.touch_x;
          tbl_y[touch_count[IdxBits-1:0]]  <= cur.touch_y;
        end
      end
    end
    if (cmd.square) begin
      rem  <= SqBits'(sqx) + SqBits'(sqy);
      root <= '0;
      rbit <= SqBits'(1) << (SqBits - 2);
      rstep <= '0;
      sumx <= SpanBits'(tbl_x[0]) + SpanBits'(tbl_x[lastix]);
      sumy <= SpanBits'(tbl_y[0]) + SpanBits'(tbl_y[lastix]);
    end
    if (cmd.root_step) begin
      if (rem >= root + rbit) begin
        rem  <= rem - (root + rbit);
        root <= (root >> 1) + rbit;
      end else begin
        root <= root >> 1;
      end
      rbit  <= rbit >> 2;
      rstep <= rstep + 1'b1;
    end
  end

  always_comb begin
    dx = SpanBits'(tbl_x[0]) - SpanBits'(tbl_x[lastix]);
    dy = SpanBits'(tbl_y[0]) - SpanBits'(tbl_y[lastix]);
  end

  // gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_limit <= TapTimeReset;
      pinch_active <= 1'b0;
      touch_count <= '0;
      tap_start_time <= '0;
      previous_span <= '0;
      first_x <= '0;
      first_y <= '0;
      mid_event <= 1'b0;
      removed_this_event <= 1'b0;
      overflow_this_event <= 1'b0;
    end else begin
      if (cfg_we) tap_limit <= cfg_data;
      if (cmd.first && !mid_event) begin
        first_x <= cur.touch_x;
        first_y <= cur.touch_y;
        if (cur.operation == OpStart) tap_start_time <= cur.event_time;
        if (cur.operation == OpMove) tap_start_time <= '0;
      end
      if (cmd.emit_end_first) begin
        touch_count <= '0;
        pinch_active <= 1'b0;
      end
      if (cmd.first) mid_event <= 1'b1;
      if (cmd.shift && stat.shift_last) begin
        touch_count <= touch_count - 1'b1;
        removed_this_event <= 1'b1;
      end
      if (cmd.table_done && (cur.operation == OpStart || cur.operation == OpAdd) && !found) begin
        if (touch_count < CntBits'(MaxTouches)) touch_count <= touch_count + 1'b1;
        else overflow_this_event <= 1'b1;
      end
      if (cmd.emit_tap_up && (cur.operation == OpStart || cur.operation == OpAdd)
          && touch_count == CntBits'(2)) begin
        tap_start_time <= '0;
      end
      if (cmd.emit_final) begin
        if (stat.pinch) begin
          pinch_active <= 1'b1;
          previous_span <= span;
        end else begin
          pinch_active <= 1'b0;
        end
      end
      if (cmd.close_event) begin
        mid_event <= 1'b0;
        removed_this_event <= 1'b0;
        overflow_this_event <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_end_first | cmd.emit_tap_ok |
                (cmd.emit_tap_up & stat.tap_hit) | cmd.emit_final;
    end
  end

  always_ff @(posedge clk) begin
    result.result_time    <= cur.event_time;
    result.table_overflow <= overflow_this_event;
    result.last_result    <= 1'b0;
    result.span_now       <= '0;
    result.span_before    <= '0;
    result.point_x        <= first_x;
    result.point_y        <= first_y;
    result.result_kind    <= KindForward;
    if (cmd.emit_end_first) begin
      result.result_kind <= KindPinchEnd;
      result.point_x <= (touch_count != '0) ? tbl_x[0] : '0;
      result.point_y <= (touch_count != '0) ? tbl_y[0] : '0;
      result.span_now <= SpanBits'(1);
      result.span_before <= SpanBits'(1);
      // a last item always adds a final result after this one
      result.last_result <= !cur.last_touch_of_event;
    end else if (cmd.emit_tap_up) begin
      result.result_kind <= KindTapUp;
    end else if (cmd.emit_tap_ok) begin
      result.result_kind <= KindTapOk;
    end else if (cmd.emit_final) begin
      result.last_result <= 1'b1;
      if (stat.pinch) begin
        result.result_kind <= pinch_active ? KindPinchScale : KindPinchStart;
        result.point_x <= fx[CoordBits-1:0];
        result.point_y <= fy[CoordBits-1:0];
        result.span_now <= span;
        result.span_before <= pinch_active ? previous_span : span;
      end else if (pinch_active) begin
        result.result_kind <= KindPinchEnd;
        result.point_x <= (touch_count != '0) ? tbl_x[0] : '0;
        result.point_y <= (touch_count != '0) ? tbl_y[0] : '0;
        result.span_now <= SpanBits'(1);
        result.span_before <= SpanBits'(1);
      end
    end
  end

endmodule

FILE: src/tptg_control.sv
// ----------------------------------------------------------------------------
// Touch pinch/tap tracker controller
// Sequences first-item actions, table scan, removal shift, tap and pinch.
// ----------------------------------------------------------------------------
module tptg_control import tptg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) state_next = S_FIRST;
      end
      S_FIRST: begin
        // pinch end reads the table before the clear lands
        cmd.first = 1'b1;
        cmd.emit_end_first = stat.first_end;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.removing) state_next = S_SHIFT;
        else if (stat.scan_last) state_next = S_DECIDE;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_last) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.table_done = 1'b1;
        state_next = stat.is_last ? S_TAP1 : S_IDLE;
      end
      S_TAP1: begin
        cmd.emit_tap_up = 1'b1;
        state_next = stat.tap_hit ? S_TAP2 : S_SQUARE;
      end
      S_TAP2: begin
        cmd.emit_tap_ok = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.emit_final = 1'b1;
        cmd.close_event = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: src/touch_pinch_tap_gesture_tracker.sv
// ----------------------------------------------------------------------------
// Touch pinch/tap gesture tracker
// Tracks active touches and reports pinch, tap and forwarded events.
// ----------------------------------------------------------------------------
// One touch item is taken when start is high and busy low. A middle item of
// an event runs the serial id scan over the table entries and, on removal,
// the removal shift; the last item adds the tap results and a 17-step
// bit-serial square root. Results appear one per strobe cycle and must be
// taken then; the receiver cannot stall.
module touch_pinch_tap_gesture_tracker import tptg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output result_t     result
);

  cmd_t       cmd;
  status_t    stat;

  assign cfg_ready = 1'b1;

  tptg_control u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  tptg_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .cfg_we  (cfg_valid),
    .cfg_data(cfg_data),
    .cmd     (cmd),
    .stat    (stat),
    .strobe  (strobe),
    .result  (result)
  );

endmodule
